// ===== hdl/sliding_median_cost_macros.svh =====
// Assertion macros for the sliding median cost block.
`ifndef SLIDING_MEDIAN_COST_MACROS_SVH
`define SLIDING_MEDIAN_COST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/smc_pkg.sv =====
// Shared types and constants for the sliding median cost block.
`default_nettype none

package smc_pkg;

    // Fixed field widths
    localparam int MED_W  = 32;
    localparam int COST_W = 41;
    localparam int CFG_W  = 11;

    // Largest possible cost, used as saturation limit
    localparam logic [COST_W-1:0] COST_HIGH = 41'd2199023255040;

    // Command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic clr;  // drop all entries
        logic ins;  // insert key in order
        logic rem;  // remove one entry equal to key
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== hdl/smc_cell.sv =====
// One cell of the sorted chain: holds one window sample and trades with its neighbors.
`default_nettype none

module smc_cell #(
    parameter int SW = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire smc_pkg::t_cell_cmd    i_cmd,
    input  wire logic signed [SW-1:0]  i_key,
    input  wire logic signed [SW-1:0]  i_left_val,
    input  wire logic                  i_left_vld,
    input  wire logic signed [SW-1:0]  i_right_val,
    input  wire logic                  i_right_vld,
    output logic signed [SW-1:0]       o_val,
    output logic                       o_vld
);

    logic signed [SW-1:0] r_val;
    logic signed [SW-1:0] n_val;
    logic                 r_vld;
    logic                 n_vld;

    // Insert shifts larger entries right; remove drops the last of an equal run
    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_cmd.clr) begin
            n_vld = 1'b0;
        end else if (i_cmd.ins) begin
            if (i_left_vld && (i_left_val > i_key)) begin
                n_val = i_left_val;
                n_vld = 1'b1;
            end else if (i_left_vld && (!r_vld || (r_val > i_key))) begin
                n_val = i_key;
                n_vld = 1'b1;
            end
        end else if (i_cmd.rem) begin
            if (r_vld && (r_val >= i_key) && !(i_right_vld && (i_right_val == i_key))) begin
                n_val = i_right_val;
                n_vld = i_right_vld;
            end
        end
    end

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Sample value
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

`default_nettype wire

// ===== hdl/smc_sel.sv =====
// Two-stage registered read of one chain position chosen by index.
`default_nettype none

module smc_sel #(
    parameter int WINDOW_MAX = 1024,
    parameter int SW         = 32,
    parameter int IDXW       = 10
) (
    input  wire logic                  i_clk,
    input  wire logic signed [SW-1:0]  i_vals [WINDOW_MAX],
    input  wire logic [IDXW-1:0]       i_idx,
    output logic signed [SW-1:0]       o_val
);

    localparam int LBW  = 5;
    localparam int LANE = 1 << LBW;
    localparam int GW   = IDXW - LBW;
    localparam int NG   = 1 << GW;

    logic signed [SW-1:0] w_pad [NG][LANE];
    logic signed [SW-1:0] r_grp [NG];
    logic [GW-1:0]        r_hi;
    logic signed [SW-1:0] r_val;

    // Pad the chain up to whole groups
    for (genvar g = 0; g < NG; g++) begin : g_grp
        for (genvar j = 0; j < LANE; j++) begin : g_lane
            if (g * LANE + j < WINDOW_MAX) begin : g_real
                assign w_pad[g][j] = i_vals[g * LANE + j];
            end else begin : g_fill
                assign w_pad[g][j] = '0;
            end
        end
    end

    // Stage 1 picks within each group, stage 2 picks the group
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NG; g++) begin
            r_grp[g] <= w_pad[g][i_idx[LBW-1:0]];
        end
        r_hi  <= i_idx[IDXW-1:LBW];
        r_val <= r_grp[r_hi];
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// ===== hdl/sliding_median_cost.sv =====
// Sliding-window median and absolute-deviation cost over a sorted chain of cells.
// Samples are accepted only in IDLE; each takes a registered chain read (SELX, WX)
// and an insert (INS), and once the window is full two more reads (SELM, SELR), MED,
// a removal (REM) and PUSH, which waits while the output is stalled.
// Reset (synchronous, active low) empties the window and sets window_size to 3;
// a window_size write or a restart item also empties the window at once.
`default_nettype none

`include "sliding_median_cost_macros.svh"

module sliding_median_cost #(
    parameter int WINDOW_MAX   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [smc_pkg::CFG_W-1:0]   i_cfg_wdata,   // window_size
    // sample stream in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [31:0]                 s_axis_tdata,  // [31:0] sample
    input  wire logic [0:0]                  s_axis_tuser,  // [0] restart
    // result stream out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [79:0]                      m_axis_tdata   // [31:0] median, [72:32] cost
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int PW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NG0  = (WINDOW_MAX + 31) / 32;
    localparam int GW   = (NG0 > 1) ? $clog2(NG0) : 1;
    localparam int IDXW = GW + 5;
    localparam int SUMW = SW + $clog2(WINDOW_MAX) + 2;
    localparam int CSTW = SUMW + 2;
    localparam int CMPW = (CSTW > smc_pkg::COST_W + 2) ? CSTW : smc_pkg::COST_W + 2;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SELX = 4'd1;
    localparam logic [3:0] ST_WX   = 4'd2;
    localparam logic [3:0] ST_INS  = 4'd3;
    localparam logic [3:0] ST_SELM = 4'd4;
    localparam logic [3:0] ST_SELR = 4'd5;
    localparam logic [3:0] ST_MED  = 4'd6;
    localparam logic [3:0] ST_REM  = 4'd7;
    localparam logic [3:0] ST_PUSH = 4'd8;

    logic [3:0]                  r_state;
    logic [3:0]                  n_state;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    logic [PW-1:0]               r_ptr;
    logic [PW-1:0]               n_ptr;
    logic signed [SUMW-1:0]      r_low;
    logic signed [SUMW-1:0]      n_low;
    logic signed [SUMW-1:0]      r_tot;
    logic signed [SUMW-1:0]      n_tot;
    logic [smc_pkg::CFG_W-1:0]   r_win;
    logic [smc_pkg::CFG_W-1:0]   n_win;

    logic signed [SW-1:0]        r_smp;
    logic signed [SW-1:0]        r_ring [WINDOW_MAX];
    logic signed [SW-1:0]        r_ring_q;
    logic [31:0]                 r_res_med;
    logic [smc_pkg::COST_W-1:0]  r_res_cost;
    logic                        r_out_valid;
    logic [31:0]                 r_out_med;
    logic [smc_pkg::COST_W-1:0]  r_out_cost;

    logic                        w_acc;
    logic                        w_clr;
    logic                        w_push_ok;
    logic [CW-1:0]               w_keff;
    logic [IDXW-1:0]             w_idx;
    logic signed [SW-1:0]        w_x;
    logic signed [SW-1:0]        w_key;
    logic signed [SW-1:0]        w_min_ins;
    logic signed [SW-1:0]        w_min_rem;
    logic [CW:0]                 w_wsum;
    logic [PW-1:0]               w_wr_addr;
    logic signed [CSTW-1:0]      w_med_term;
    logic signed [CSTW-1:0]      w_cost;
    logic [CMPW-1:0]             w_cost_ext;
    logic [smc_pkg::COST_W-1:0]  w_cost_sat;
    smc_pkg::t_cell_cmd          w_cmd;
    logic signed [SW-1:0]        w_val [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]       w_vld;

    // Handshake and window clear
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_clr         = i_cfg_we || (w_acc && s_axis_tuser[0]);
    assign w_push_ok     = !r_out_valid || m_axis_tready;

    // Effective window length, clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_win == '0) begin
            w_keff = CW'(1);
        end else if (32'(r_win) > 32'(WINDOW_MAX)) begin
            w_keff = CW'(WINDOW_MAX);
        end else begin
            w_keff = CW'(r_win);
        end
    end

    // Chain command
    always_comb begin
        w_cmd.clr = w_clr;
        w_cmd.ins = (r_state == ST_INS);
        w_cmd.rem = (r_state == ST_REM);
    end
    assign w_key = (r_state == ST_REM) ? r_ring_q : r_smp;

    // Sorted chain of cells
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic signed [SW-1:0] w_lv;
        logic signed [SW-1:0] w_rv;
        logic                 w_lok;
        logic                 w_rok;
        if (i == 0) begin : g_head
            assign w_lv  = {1'b1, {(SW-1){1'b0}}};
            assign w_lok = 1'b1;
        end else begin : g_mid_l
            assign w_lv  = w_val[i-1];
            assign w_lok = w_vld[i-1];
        end
        if (i == WINDOW_MAX - 1) begin : g_tail
            assign w_rv  = '0;
            assign w_rok = 1'b0;
        end else begin : g_mid_r
            assign w_rv  = w_val[i+1];
            assign w_rok = w_vld[i+1];
        end
        smc_cell #(
            .SW(SW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_key       (w_key),
            .i_left_val  (w_lv),
            .i_left_vld  (w_lok),
            .i_right_val (w_rv),
            .i_right_vld (w_rok),
            .o_val       (w_val[i]),
            .o_vld       (w_vld[i])
        );
    end

    // Chain read index: median position in SELM, half-count otherwise
    always_comb begin
        if (r_state == ST_SELM) begin
            w_idx = IDXW'((r_count - CW'(1)) >> 1);
        end else begin
            w_idx = IDXW'(r_count >> 1);
        end
    end

    smc_sel #(
        .WINDOW_MAX (WINDOW_MAX),
        .SW         (SW),
        .IDXW       (IDXW)
    ) u_sel (
        .i_clk  (i_clk),
        .i_vals (w_val),
        .i_idx  (w_idx),
        .o_val  (w_x)
    );

    // Boundary element against the incoming and the leaving sample
    assign w_min_ins = (r_smp < w_x) ? r_smp : w_x;
    assign w_min_rem = (r_ring_q < w_x) ? r_ring_q : w_x;

    // Ring slot of the newest sample
    always_comb begin
        w_wsum = (CW+1)'(r_ptr) + (CW+1)'(r_count);
        if (w_wsum >= (CW+1)'(WINDOW_MAX)) begin
            w_wsum = w_wsum - (CW+1)'(WINDOW_MAX);
        end
        w_wr_addr = PW'(w_wsum);
    end

    // cost = total - 2*lower + median when the count is odd
    assign w_med_term = r_count[0] ? CSTW'(w_x) : CSTW'(0);
    assign w_cost     = CSTW'(r_tot) - (CSTW'(r_low) <<< 1) + w_med_term;
    assign w_cost_ext = CMPW'(w_cost);
    always_comb begin
        if (w_cost[CSTW-1]) begin
            w_cost_sat = '0;
        end else if (w_cost_ext > CMPW'(smc_pkg::COST_HIGH)) begin
            w_cost_sat = smc_pkg::COST_HIGH;
        end else begin
            w_cost_sat = w_cost_ext[smc_pkg::COST_W-1:0];
        end
    end

    // Sequencer and running sums
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_low   = r_low;
        n_tot   = r_tot;
        n_win   = r_win;
        if (i_cfg_we) begin
            n_win = i_cfg_wdata;
        end
        if (w_clr) begin
            n_count = '0;
            n_ptr   = '0;
            n_low   = '0;
            n_tot   = '0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = ST_SELX;
                end
            end
            ST_SELX: n_state = ST_WX;
            ST_WX:   n_state = ST_INS;
            ST_INS: begin
                n_tot = r_tot + SUMW'(r_smp);
                if (r_count == '0) begin
                    n_low = SUMW'(r_smp);
                end else if (r_count[0]) begin
                    n_low = r_low - SUMW'(w_x) + SUMW'(w_min_ins);
                end else begin
                    n_low = r_low + SUMW'(w_min_ins);
                end
                n_count = r_count + CW'(1);
                n_state = (n_count >= w_keff) ? ST_SELM : ST_IDLE;
            end
            ST_SELM: n_state = ST_SELR;
            ST_SELR: n_state = ST_MED;
            ST_MED:  n_state = ST_REM;
            ST_REM: begin
                n_tot = r_tot - SUMW'(r_ring_q);
                if (r_count[0]) begin
                    n_low = r_low - SUMW'(w_min_rem);
                end else begin
                    n_low = r_low + SUMW'(w_x) - SUMW'(w_min_rem);
                end
                n_count = r_count - CW'(1);
                n_ptr   = (r_ptr == PW'(WINDOW_MAX - 1)) ? '0 : r_ptr + PW'(1);
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (w_push_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
            r_low   <= '0;
            r_tot   <= '0;
            r_win   <= smc_pkg::CFG_W'(3);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_low   <= n_low;
            r_tot   <= n_tot;
            r_win   <= n_win;
        end
    end

    // Sample latch, median and cost capture
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_smp <= s_axis_tdata[SW-1:0];
        end
        if (r_state == ST_MED) begin
            r_res_med  <= 32'(w_x);
            r_res_cost <= w_cost_sat;
        end
    end

    // Arrival ring: write newest in INS, read oldest in SELM
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INS) begin
            r_ring[w_wr_addr] <= r_smp;
        end
        if (r_state == ST_SELM) begin
            r_ring_q <= r_ring[r_ptr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_PUSH) && w_push_ok) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_PUSH) && w_push_ok) begin
            r_out_med  <= r_res_med;
            r_out_cost <= r_res_cost;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_cost, r_out_med};

    // Checks
    `SMC_ASSERT_NOW(a_idle_below_window, r_state == ST_IDLE, r_count < w_keff,
        "window still full while idle")
    `SMC_ASSERT_NOW(a_chain_matches_count, r_state == ST_IDLE,
        $countones(w_vld) == int'(r_count), "chain occupancy differs from count")
    `SMC_ASSERT_NOW(a_cost_in_range, r_out_valid, r_out_cost <= smc_pkg::COST_HIGH,
        "cost above limit")
    `SMC_ASSERT_NEXT(a_busy_after_accept, w_acc, !s_axis_tready,
        "new item taken while one is in work")

endmodule

`default_nettype wire
